// ===== design/float32_to_pcm16_converter_core_macros.svh =====
// Assertion macros used by the converter core RTL.
// Each macro checks an implication on the rising edge of clk, disabled in reset.
`ifndef FLOAT32_TO_PCM16_CONVERTER_CORE_MACROS_SVH
`define FLOAT32_TO_PCM16_CONVERTER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define F2P_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define F2P_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/f2p_pkg.sv =====
// ----------------------------------------------------------------------------
// f2p_pkg
// Types and constants shared by the float32 to PCM16 converter.
// ----------------------------------------------------------------------------
package f2p_pkg;

    // Input item: raw single-precision sample and the end-of-buffer marker.
    typedef struct packed {
        logic [31:0] sample_bits;
        logic        in_last;
    } f2p_in_t;

    // Result item: signed PCM sample and the end-of-buffer marker.
    typedef struct packed {
        logic signed [15:0] pcm_sample;
        logic               out_last;
    } f2p_out_t;

    localparam logic signed [15:0] PCM_MAX = 16'sh7FFF;
    localparam logic signed [15:0] PCM_MIN = 16'sh8000;
    localparam logic [7:0]         EXP_SPECIAL = 8'hFF;
    localparam logic [7:0]         EXP_ZERO    = 8'h00;

    // Exponent bounds on the rounded significand R, with value R * 2^E.
    // The bias is 127 + 23 for the float, less 14 for the bits dropped from
    // the product when its top bit is bit 37.
    localparam logic signed [9:0]  E_HUGE  = 10'sd8;
    localparam logic signed [9:0]  E_SAT   = -10'sd8;
    localparam logic signed [9:0]  E_SMALL = -10'sd23;
    localparam logic signed [9:0]  E_BIAS  = 10'sd136;

endpackage

// ===== design/f2p_conv.sv =====
// ----------------------------------------------------------------------------
// f2p_conv
// Combinational scale by 32767 with round-to-nearest-even, then truncation
// toward zero and saturation into signed 16 bits.
// ----------------------------------------------------------------------------
module f2p_conv
(
    input  logic [31:0]        sample_bits,
    output logic signed [15:0] pcm_sample
);

    logic              sign_bit;
    logic [7:0]        exp_field;
    logic [23:0]       mant;
    logic [38:0]       prod;
    logic              prod_hi;
    logic [23:0]       top;
    logic              guard_bit;
    logic              sticky;
    logic              round_up;
    logic [24:0]       rounded;
    logic              carry;
    logic [23:0]       sig;
    logic signed [9:0] exp_val;
    logic signed [9:0] neg_exp;
    logic [23:0]       shifted;
    logic [14:0]       mag;

    // Split the sample; the hidden one is only used on normal inputs.
    assign sign_bit  = sample_bits[31];
    assign exp_field = sample_bits[30:23];
    assign mant      = {1'b1, sample_bits[22:0]};

    // Exact product with 32767 as a shift and subtract.
    assign prod = {mant, 15'b0} - {15'b0, mant};

    // Keep 24 significant bits, then round to nearest even.
    assign prod_hi   = prod[38];
    assign top       = prod_hi ? prod[38:15] : prod[37:14];
    assign guard_bit = prod_hi ? prod[14] : prod[13];
    assign sticky    = prod_hi ? (|prod[13:0]) : (|prod[12:0]);
    assign round_up  = guard_bit & (sticky | top[0]);
    assign rounded   = {1'b0, top} + {24'b0, round_up};
    assign carry     = rounded[24];
    assign sig       = carry ? 24'h800000 : rounded[23:0];

    // Weight of the least significant bit of the rounded significand.
    assign exp_val = signed'({2'b00, exp_field}) - f2p_pkg::E_BIAS
                   + signed'({9'b0, prod_hi}) + signed'({9'b0, carry});
    assign neg_exp = 10'sd0 - exp_val;

    // Truncate toward zero; only used when the shift lies between 9 and 23.
    assign shifted = sig >> neg_exp[4:0];
    assign mag     = shifted[14:0];

    // Select the result by range of the rounded product.
    always_comb
    begin
        if (exp_field == f2p_pkg::EXP_SPECIAL) begin
            pcm_sample = f2p_pkg::PCM_MIN;
        end
        else if (exp_field == f2p_pkg::EXP_ZERO) begin
            pcm_sample = 16'sd0;
        end
        else if (exp_val >= f2p_pkg::E_HUGE) begin
            pcm_sample = f2p_pkg::PCM_MIN;
        end
        else if (exp_val >= f2p_pkg::E_SAT) begin
            pcm_sample = sign_bit ? f2p_pkg::PCM_MIN : f2p_pkg::PCM_MAX;
        end
        else if (exp_val < f2p_pkg::E_SMALL) begin
            pcm_sample = 16'sd0;
        end
        else begin
            pcm_sample = sign_bit ? (16'sd0 - signed'({1'b0, mag})) : signed'({1'b0, mag});
        end
    end

endmodule

// ===== design/float32_to_pcm16_converter_core.sv =====
// An accepted item moves from the input register through the conversion into the result register.
// Throughput: one item per cycle while pcm_ready is set; a stage refills in the cycle it empties.
// Reset clears both stage valid flags; payload registers are not reset.
// ----------------------------------------------------------------------------
// float32_to_pcm16_converter_core
// Converts single-precision audio samples into signed 16-bit PCM samples.
// ----------------------------------------------------------------------------
`include "float32_to_pcm16_converter_core_macros.svh"

module float32_to_pcm16_converter_core
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              sample_valid,
    output logic              sample_ready,
    input  f2p_pkg::f2p_in_t  sample,
    output logic              pcm_valid,
    input  logic              pcm_ready,
    output f2p_pkg::f2p_out_t pcm
);

    logic               in_valid_reg;
    f2p_pkg::f2p_in_t   in_data_reg;
    logic               out_valid_reg;
    f2p_pkg::f2p_out_t  out_data_reg;
    logic               out_free;
    logic               in_free;
    logic               in_valid_next;
    logic               out_valid_next;
    logic signed [15:0] conv_pcm;

    // Each stage may load when it is empty or is emptied this cycle.
    assign out_free     = !out_valid_reg || pcm_ready;
    assign in_free      = !in_valid_reg || out_free;
    assign sample_ready = in_free;

    assign in_valid_next  = sample_valid ? 1'b1 : (in_valid_reg && !out_free);
    assign out_valid_next = out_free ? in_valid_reg : 1'b1;

    // The conversion sits between the input and the result register.
    f2p_conv u_conv
    (
        .sample_bits (in_data_reg.sample_bits),
        .pcm_sample  (conv_pcm)
    );

    // Valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_free)
            begin
                in_valid_reg <= in_valid_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_free && sample_valid)
        begin
            in_data_reg <= sample;
        end
        if (out_free && in_valid_reg)
        begin
            out_data_reg.pcm_sample <= conv_pcm;
            out_data_reg.out_last   <= in_data_reg.in_last;
        end
    end

    assign pcm_valid = out_valid_reg;
    assign pcm       = out_data_reg;

    // Checks on the pipeline control.
    `F2P_ASSERT_SAME(a_ready_only_when_full, !sample_ready,
        in_valid_reg && out_valid_reg, "input stalled while a stage is empty")
    `F2P_ASSERT_NEXT(a_advance_fills_out, in_valid_reg && out_free,
        out_valid_reg, "advancing item lost")
    `F2P_ASSERT_NEXT(a_stalled_in_holds, in_valid_reg && !out_free,
        in_valid_reg && $stable(in_data_reg), "stalled input stage changed")

endmodule

// ===== sim/float32_to_pcm16_converter_core_tb.sv =====
// ----------------------------------------------------------------------------
// float32_to_pcm16_converter_core_tb
// Self-checking bench for the float32 to PCM16 converter. A directed table of
// corner samples is followed by random samples that are mostly in the audio
// range. Both handshakes idle at random, the receiver is held off for a long
// stretch once, and every result is checked against a typed-in value or a
// bit-exact model of the scale, round, truncate and saturate steps.
// ----------------------------------------------------------------------------
module float32_to_pcm16_converter_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_REPORTS = 10;
    localparam int RANDOM_ITEMS = 950;
    localparam int HOLD_LEN = 200;

    // One row of the directed table.
    typedef struct {
        logic [31:0]        bits;
        logic               last;
        bit                 fixed;
        logic signed [15:0] pcm;
    } sample_row_t;

    logic               clk;
    logic               rst_n;
    logic               sample_valid;
    logic               sample_ready;
    f2p_pkg::f2p_in_t   sample;
    logic               pcm_valid;
    logic               pcm_ready;
    f2p_pkg::f2p_out_t  pcm;

    // Expected result attached to the item currently offered, if typed in.
    bit                 cur_fixed;
    logic signed [15:0] cur_fixed_pcm;

    f2p_pkg::f2p_out_t  pcm_expected[$];
    int                 err_count;
    int                 tx_idle_pct;
    int                 rx_idle_pct;
    bit                 hold_req;
    bit                 hold_taken;
    int                 hold_cycles;

    float32_to_pcm16_converter_core dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .pcm_valid    (pcm_valid),
        .pcm_ready    (pcm_ready),
        .pcm          (pcm)
    );

    // Clock with an 8 ns period.
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Scale by 32767 with round-to-nearest-even on a 24-bit significand, then
    // truncate toward zero and saturate. Products below one always give zero,
    // so the flush of tiny products needs no separate handling.
    function automatic logic signed [15:0] pcm_of_float(logic [31:0] b);
        logic        sgn;
        logic [7:0]  ex;
        logic [22:0] fr;
        logic [38:0] prod;
        logic [23:0] rnd;
        logic [63:0] whole;
        logic        guard;
        logic        sticky;
        int          e2;
        int          msb;
        int          sh;
        sgn = b[31];
        ex  = b[30:23];
        fr  = b[22:0];
        if (ex == f2p_pkg::EXP_SPECIAL)
            return f2p_pkg::PCM_MIN;
        if (ex == f2p_pkg::EXP_ZERO)
        begin
            prod = 39'(fr) * 39'd32767;
            e2   = -149;
        end
        else
        begin
            prod = 39'({1'b1, fr}) * 39'd32767;
            e2   = int'(ex) - 150;
        end
        if (prod == 0)
            return 16'sd0;
        msb = 0;
        for (int i = 0; i < 39; i++)
            if (prod[i])
                msb = i;
        if (msb > 23)
        begin
            sh     = msb - 23;
            rnd    = 24'(prod >> sh);
            guard  = prod[sh - 1];
            sticky = (prod & ((39'd1 << (sh - 1)) - 39'd1)) != 0;
            if (guard && (sticky || rnd[0]))
            begin
                if (rnd == 24'hFFFFFF)
                begin
                    rnd = 24'h800000;
                    sh++;
                end
                else
                    rnd++;
            end
            e2 += sh;
        end
        else
            rnd = prod[23:0];
        // Magnitude of at least 2^31 gives the integer-indefinite value.
        if (e2 >= 8)
            return f2p_pkg::PCM_MIN;
        if (e2 >= 0)
            whole = 64'(rnd) << e2;
        else if (e2 < -40)
            whole = 64'd0;
        else
            whole = 64'(rnd) >> (-e2);
        if (sgn)
            return (whole >= 64'd32768) ? f2p_pkg::PCM_MIN : 16'(~whole[15:0] + 16'd1);
        return (whole > 64'd32767) ? f2p_pkg::PCM_MAX : 16'(whole);
    endfunction

    // Random sample: mostly audio range, some across the overflow boundary,
    // some with an all-ones or all-zero exponent, some raw bit patterns.
    function automatic logic [31:0] random_sample();
        int pick;
        pick = $urandom_range(99);
        if (pick < 60)
            return {1'($urandom), 8'($urandom_range(127, 100)), 23'($urandom)};
        if (pick < 75)
            return {1'($urandom), 8'($urandom_range(160, 134)), 23'($urandom)};
        if (pick < 82)
            return {1'($urandom),
                    ($urandom_range(1) ? f2p_pkg::EXP_SPECIAL : f2p_pkg::EXP_ZERO),
                    23'($urandom)};
        return 32'($urandom);
    endfunction

    // Offer one item and wait until it is taken; valid is left high unless a random idle follows.
    task automatic offer_sample(logic [31:0] bits, logic last, bit fixed,
                                logic signed [15:0] fixed_pcm);
        sample_valid  <= 1'b1;
        sample        <= '{sample_bits: bits, in_last: last};
        cur_fixed     <= fixed;
        cur_fixed_pcm <= fixed_pcm;
        do
            @(posedge clk);
        while (!sample_ready);
        if ($urandom_range(99) < tx_idle_pct)
        begin
            sample_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < tx_idle_pct);
        end
    endtask

    // Receiver: random back-pressure, or one long hold-off when requested.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pcm_ready   <= 1'b0;
            hold_taken  <= 1'b0;
            hold_cycles <= 0;
        end
        else if (hold_req && !hold_taken)
        begin
            hold_taken  <= 1'b1;
            hold_cycles <= HOLD_LEN - 1;
            pcm_ready   <= 1'b0;
        end
        else if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            pcm_ready   <= 1'b0;
        end
        else
            pcm_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Record the expected result of every accepted item.
    always @(posedge clk)
    begin
        if (rst_n && sample_valid && sample_ready)
            pcm_expected.push_back('{pcm_sample: cur_fixed ? cur_fixed_pcm
                                                     : pcm_of_float(sample.sample_bits),
                                     out_last: sample.in_last});
    end

    // Compare every accepted result with the oldest expectation.
    always @(posedge clk)
    begin
        f2p_pkg::f2p_out_t want;
        if (rst_n && pcm_valid && pcm_ready)
        begin
            if (pcm_expected.size() == 0)
            begin
                err_count++;
                if (err_count <= MAX_REPORTS)
                    $display("unexpected result: pcm=%0d last=%0b",
                             pcm.pcm_sample, pcm.out_last);
            end
            else
            begin
                want = pcm_expected.pop_front();
                if (pcm.pcm_sample !== want.pcm_sample || pcm.out_last !== want.out_last)
                begin
                    err_count++;
                    if (err_count <= MAX_REPORTS)
                        $display("mismatch: expected pcm=%0d last=%0b, got pcm=%0d last=%0b",
                                 want.pcm_sample, want.out_last,
                                 pcm.pcm_sample, pcm.out_last);
                end
            end
        end
    end

    // Stimulus and end of run.
    initial
    begin
        sample_row_t corners[$];
        int          n;
        corners = '{
            '{32'h00000000, 1'b0, 1'b1, 16'sd0},
            '{32'h80000000, 1'b1, 1'b1, 16'sd0},
            '{32'h3F800000, 1'b0, 1'b1, 16'sd32767},
            '{32'hBF800000, 1'b1, 1'b1, -16'sd32767},
            '{32'h40000000, 1'b0, 1'b1, f2p_pkg::PCM_MAX},
            '{32'hC0000000, 1'b0, 1'b1, f2p_pkg::PCM_MIN},
            '{32'h7F800000, 1'b1, 1'b1, f2p_pkg::PCM_MIN},
            '{32'hFF800000, 1'b0, 1'b1, f2p_pkg::PCM_MIN},
            '{32'h7FC00000, 1'b0, 1'b1, f2p_pkg::PCM_MIN},
            '{32'hFFFFFFFF, 1'b1, 1'b1, f2p_pkg::PCM_MIN},
            '{32'h7F7FFFFF, 1'b0, 1'b1, f2p_pkg::PCM_MIN},
            '{32'hFF7FFFFF, 1'b0, 1'b1, f2p_pkg::PCM_MIN},
            '{32'h00000001, 1'b1, 1'b1, 16'sd0},
            '{32'h807FFFFF, 1'b0, 1'b1, 16'sd0},
            '{32'h3F000000, 1'b0, 1'b1, 16'sd16383},
            '{32'h38000000, 1'b0, 1'b0, 16'sd0},
            '{32'h47800000, 1'b1, 1'b0, 16'sd0},
            '{32'h47800100, 1'b0, 1'b0, 16'sd0},
            '{32'hC7800000, 1'b0, 1'b0, 16'sd0},
            '{32'h3F7FFFFF, 1'b1, 1'b0, 16'sd0},
            '{32'hBF000001, 1'b0, 1'b0, 16'sd0},
            '{32'h5555AAAA, 1'b1, 1'b0, 16'sd0},
            '{32'hAAAA5555, 1'b0, 1'b0, 16'sd0}
        };
        rst_n         = 1'b0;
        sample_valid  = 1'b0;
        sample        = '0;
        cur_fixed     = 1'b0;
        cur_fixed_pcm = '0;
        err_count     = 0;
        hold_req      = 1'b0;
        tx_idle_pct   = 12;
        rx_idle_pct   = 61;
        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed corners.
        foreach (corners[i])
            offer_sample(corners[i].bits, corners[i].last,
                         corners[i].fixed, corners[i].pcm);

        // Random samples in three idling phases.
        n = 0;
        for (int ph = 0; ph < 3; ph++)
        begin
            tx_idle_pct = (ph == 0) ? 12 : (ph == 1) ? 61 : 0;
            rx_idle_pct = (ph == 0) ? 61 : (ph == 1) ? 12 : 0;
            // Long receiver hold-off while items keep coming, to fill the block.
            if (ph == 2)
                hold_req = 1'b1;
            while (n < (ph + 1) * RANDOM_ITEMS / 3)
            begin
                offer_sample(random_sample(), 1'($urandom), 1'b0, 16'sd0);
                n++;
                // Sender pause until every expected result has come.
                if (ph == 1 && n == RANDOM_ITEMS / 2)
                begin
                    sample_valid <= 1'b0;
                    @(posedge clk);
                    while (pcm_expected.size() != 0)
                        @(posedge clk);
                end
            end
        end
        sample_valid <= 1'b0;

        while (pcm_expected.size() != 0)
            @(posedge clk);
        repeat (10)
            @(posedge clk);
        if (err_count == 0)
            $display("float32_to_pcm16_converter_core_tb: PASS");
        else
            $display("float32_to_pcm16_converter_core_tb: FAIL");
        $finish;
    end

    // Run limit.
    initial
    begin
        #2000000;
        $display("float32_to_pcm16_converter_core_tb: FAIL");
        $finish;
    end

endmodule
